// ===== hdl/stereo_audio_fifo_with_gain_defines.svh =====
// ----------------------------------------------------------------------------
// stereo audio fifo with gain: assertion macros
// shared concurrent assertion forms, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef STEREO_AUDIO_FIFO_WITH_GAIN_DEFINES_SVH
`define STEREO_AUDIO_FIFO_WITH_GAIN_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define SAF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("saf assertion failed");

// next-cycle implication, checked out of reset
`define SAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("saf assertion failed");

`else

`define SAF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SAF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/saf_pkg.sv =====
// ----------------------------------------------------------------------------
// saf_pkg
// types and constants shared by the stereo audio fifo with gain
// ----------------------------------------------------------------------------
package saf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int VOL_W    = 16;
    localparam int FILL_W   = 10;

    // gain limits, unsigned q2.14
    localparam logic [VOL_W-1:0] VOL_MAX   = 16'd32768;
    localparam logic [VOL_W-1:0] VOL_UNITY = 16'd16384;

    // rounding offset for the q3.29 to q1.15 step
    localparam logic signed [32:0] ROUND_HALF = 33'sd8192;

    // clamp limits on the 19-bit rounded product
    localparam logic signed [18:0] CLAMP_HI = 19'sd32767;
    localparam logic signed [18:0] CLAMP_LO = -19'sd32768;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_PULL  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // one stereo frame as held in the ring
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } frame_t;

    // one result word
    typedef struct packed {
        logic                       accepted;
        logic                       frame_valid;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [FILL_W-1:0]          fill_level;
    } result_t;

endpackage

// ===== hdl/saf_if.sv =====
// ----------------------------------------------------------------------------
// saf channel interfaces
// valid/ready channels for command words, result words and the gain register
// ----------------------------------------------------------------------------
interface saf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] left_in;
    logic [15:0] right_in;

    modport source (output valid, output command, output left_in, output right_in,
                    input ready);
    modport sink   (input valid, input command, input left_in, input right_in,
                    output ready);
endinterface

interface saf_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        frame_valid;
    logic [15:0] left_out;
    logic [15:0] right_out;
    logic [9:0]  fill_level;

    modport source (output valid, output accepted, output frame_valid,
                    output left_out, output right_out, output fill_level,
                    input ready);
    modport sink   (input valid, input accepted, input frame_valid,
                    input left_out, input right_out, input fill_level,
                    output ready);
endinterface

interface saf_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] volume;

    modport source (output valid, output volume, input ready);
    modport sink   (input valid, input volume, output ready);
endinterface

// ===== hdl/saf_frame_ram.sv =====
// ----------------------------------------------------------------------------
// saf_frame_ram
// ring storage of stereo frames, one write and one registered read port
// ----------------------------------------------------------------------------
module saf_frame_ram
    import saf_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  frame_t                   wr_frame,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output frame_t                   rd_frame
);

    frame_t frame_mem [DEPTH];
    frame_t rd_frame_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_addr] <= wr_frame;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_frame_reg <= frame_mem[rd_addr];
        end
    end

    assign rd_frame = rd_frame_reg;

endmodule

// ===== hdl/saf_gain.sv =====
// ----------------------------------------------------------------------------
// saf_gain
// one channel of gain: registered product, then rounding and clamping
// ----------------------------------------------------------------------------
module saf_gain
    import saf_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [VOL_W-1:0]           volume,
    output logic signed [SAMPLE_W-1:0] scaled
);

    logic signed [VOL_W:0]  vol_s;
    logic signed [32:0]     prod_next;
    logic signed [32:0]     prod_reg;
    logic signed [32:0]     rounded;
    logic signed [18:0]     q;

    // q1.15 times q2.14 gives an exact q3.29 product
    assign vol_s     = $signed({1'b0, volume});
    assign prod_next = sample * vol_s;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    // round to nearest, ties upward, then floor shift by 14
    assign rounded = prod_reg + ROUND_HALF;
    assign q       = $signed(rounded[32:14]);

    // clamp to full scale
    always_comb
    begin
        if (q > CLAMP_HI)
        begin
            scaled = CLAMP_HI[SAMPLE_W-1:0];
        end
        else if (q < CLAMP_LO)
        begin
            scaled = CLAMP_LO[SAMPLE_W-1:0];
        end
        else
        begin
            scaled = q[SAMPLE_W-1:0];
        end
    end

endmodule

// ===== hdl/saf_ctrl.sv =====
// ----------------------------------------------------------------------------
// saf_ctrl
// ring pointers, command sequencing, result and output registers
// ----------------------------------------------------------------------------
module saf_ctrl
    import saf_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    saf_in_if.sink                     item,
    saf_out_if.source                  result,
    output logic                       ram_wr_en,
    output logic [$clog2(DEPTH)-1:0]   ram_wr_addr,
    output frame_t                     ram_wr_frame,
    output logic                       ram_rd_en,
    output logic [$clog2(DEPTH)-1:0]   ram_rd_addr,
    output logic                       gain_en,
    input  logic signed [SAMPLE_W-1:0] gain_left,
    input  logic signed [SAMPLE_W-1:0] gain_right
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W  = (AW+1)'(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_MULT = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    result_t       res_reg, res_next;
    result_t       out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic [AW:0]   diff;
    logic [AW-1:0] fill_cur;
    logic [AW-1:0] fill_after;
    logic          take;
    logic          out_free;
    logic          has_room;
    logic          has_data;
    cmd_t          cmd;

    // fill level of the ring, wrapped modulo depth
    assign diff     = {1'b0, wr_idx_reg} - {1'b0, rd_idx_reg};
    assign fill_cur = diff[AW] ? AW'(diff + DEPTH_W) : diff[AW-1:0];
    assign has_room = (fill_cur < LAST_IDX);
    assign has_data = (fill_cur != '0);

    assign cmd      = cmd_t'(item.command);
    assign take     = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;

    assign item.ready = (state_reg == ST_IDLE);

    // memory accesses start on the accepting edge; one item at a time,
    // so a read never overlaps a write to the same slot
    assign ram_wr_en          = take && (cmd == CMD_PUSH) && has_room;
    assign ram_wr_addr        = wr_idx_reg;
    assign ram_wr_frame.left  = item.left_in;
    assign ram_wr_frame.right = item.right_in;
    assign ram_rd_en          = take && (cmd == CMD_PULL) && has_data;
    assign ram_rd_addr        = rd_idx_reg;
    assign gain_en            = (state_reg == ST_READ);

    // sequencer and pointer update
    always_comb
    begin
        state_next     = state_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        fill_after     = fill_cur;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    res_next.accepted    = 1'b0;
                    res_next.frame_valid = 1'b0;
                    res_next.left        = '0;
                    res_next.right       = '0;
                    state_next           = ST_DONE;
                    case (cmd)
                        CMD_PUSH:
                        begin
                            if (has_room)
                            begin
                                wr_idx_next       = (wr_idx_reg == LAST_IDX) ? '0
                                                    : wr_idx_reg + 1'b1;
                                fill_after        = fill_cur + 1'b1;
                                res_next.accepted = 1'b1;
                            end
                        end
                        CMD_PULL:
                        begin
                            if (has_data)
                            begin
                                rd_idx_next          = (rd_idx_reg == LAST_IDX) ? '0
                                                       : rd_idx_reg + 1'b1;
                                fill_after           = fill_cur - 1'b1;
                                res_next.frame_valid = 1'b1;
                                state_next           = ST_READ;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            rd_idx_next = wr_idx_reg;
                            fill_after  = '0;
                        end
                        default:
                        begin
                            fill_after = fill_cur;
                        end
                    endcase
                    res_next.fill_level = FILL_W'(fill_after);
                end
            end
            ST_READ:
            begin
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                res_next.left  = gain_left;
                res_next.right = gain_right;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.accepted    = out_reg.accepted;
    assign result.frame_valid = out_reg.frame_valid;
    assign result.left_out    = out_reg.left;
    assign result.right_out   = out_reg.right;
    assign result.fill_level  = out_reg.fill_level;

endmodule

// ===== hdl/stereo_audio_fifo_with_gain.sv =====
// ----------------------------------------------------------------------------
// stereo_audio_fifo_with_gain
// ring fifo of stereo frames with output gain and full-scale clamping
// ----------------------------------------------------------------------------
// usage
//   item: command words (push, pull, clear, no-op) with left/right samples;
//   one result word per command word on result: accepted flag, frame_valid
//   flag, gain-scaled samples and the fill level after the command.
//   cfg: write channel for the volume register (q2.14, clamped to 2.0),
//   always ready; write it only while the block is idle.
//   the ring holds up to DEPTH-1 frames; a push into a full ring is refused,
//   a pull from an empty ring returns silence with frame_valid low.
// sequencing
//   push, clear and no-op words go from acceptance to the done state; a pull
//   with data first passes memory read, multiply, round and clamp. item is
//   accepted again once the result has moved to the output register, so the
//   block takes a new word only once the last one is through, limited by the
//   single sequencer around the frame memory.
// reset and stalls
//   reset empties the ring and sets unity gain; memory contents are not
//   cleared. if result is stalled, one finished word waits in the output
//   register while the next word is accepted and processed, then item holds.
// ----------------------------------------------------------------------------
`include "stereo_audio_fifo_with_gain_defines.svh"

module stereo_audio_fifo_with_gain
    import saf_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    saf_in_if.sink     item,
    saf_out_if.source  result,
    saf_cfg_if.sink    cfg
);

    localparam int AW = $clog2(DEPTH);

    logic [VOL_W-1:0]           volume_reg, volume_next;
    logic                       ram_wr_en;
    logic [AW-1:0]              ram_wr_addr;
    frame_t                     ram_wr_frame;
    logic                       ram_rd_en;
    logic [AW-1:0]              ram_rd_addr;
    frame_t                     ram_rd_frame;
    logic                       gain_en;
    logic signed [SAMPLE_W-1:0] gain_left;
    logic signed [SAMPLE_W-1:0] gain_right;

    // volume register, clamped to 2.0 on write
    assign cfg.ready   = 1'b1;
    assign volume_next = (cfg.volume > VOL_MAX) ? VOL_MAX : cfg.volume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg <= VOL_UNITY;
        end
        else if (cfg.valid && cfg.ready)
        begin
            volume_reg <= volume_next;
        end
    end

    // sequencer and pointers
    saf_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .result       (result),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_frame (ram_wr_frame),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .gain_en      (gain_en),
        .gain_left    (gain_left),
        .gain_right   (gain_right)
    );

    // frame storage
    saf_frame_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk      (clk),
        .wr_en    (ram_wr_en),
        .wr_addr  (ram_wr_addr),
        .wr_frame (ram_wr_frame),
        .rd_en    (ram_rd_en),
        .rd_addr  (ram_rd_addr),
        .rd_frame (ram_rd_frame)
    );

    // gain on each channel
    saf_gain u_gain_left (
        .clk    (clk),
        .en     (gain_en),
        .sample (ram_rd_frame.left),
        .volume (volume_reg),
        .scaled (gain_left)
    );

    saf_gain u_gain_right (
        .clk    (clk),
        .en     (gain_en),
        .sample (ram_rd_frame.right),
        .volume (volume_reg),
        .scaled (gain_right)
    );

    // checks
    `SAF_ASSERT_IMPL(a_vol_range, clk, rst_n, 1'b1, volume_reg <= VOL_MAX)
    `SAF_ASSERT_NEXT(a_busy_after_take, clk, rst_n, item.valid && item.ready, !item.ready)
    `SAF_ASSERT_NEXT(a_read_feeds_gain, clk, rst_n, ram_rd_en, gain_en)
    `SAF_ASSERT_IMPL(a_one_flag, clk, rst_n, result.valid,
                     !(result.accepted && result.frame_valid))

endmodule

// ===== sim/stereo_audio_fifo_with_gain_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_audio_fifo_with_gain_tb
// drives push, pull, clear and no-op words into the audio ring, keeps its own
// copy of the ring and the gain register, and checks every result word field
// by field against the predicted word, in order, under varied idling and stalls
// ----------------------------------------------------------------------------
module stereo_audio_fifo_with_gain_tb
    import saf_pkg::*;
;

    // ring predictor and result checker
    class audio_ring_scoreboard;
        localparam int RING_DEPTH = 1024;

        logic signed [15:0] left_ring [RING_DEPTH];
        logic signed [15:0] right_ring [RING_DEPTH];
        int unsigned        wr_ptr;
        int unsigned        rd_ptr;
        logic [15:0]        gain;
        result_t            pending_results [$];
        int                 error_count;
        int                 word_count;

        function new();
            wr_ptr      = 0;
            rd_ptr      = 0;
            gain        = VOL_UNITY;
            error_count = 0;
            word_count  = 0;
        endfunction

        // register write, clamped to 2.0
        function void set_gain(logic [15:0] value);
            gain = (value > VOL_MAX) ? VOL_MAX : value;
        endfunction

        function int unsigned frames_held();
            return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction

        // q1.15 times q2.14, round half up, clamp to full scale
        function logic signed [15:0] scaled_sample(logic signed [15:0] sample);
            longint prod;
            prod = (longint'(sample) * longint'(gain) + 8192) >>> 14;
            if (prod > 32767)
                prod = 32767;
            else if (prod < -32768)
                prod = -32768;
            return prod[15:0];
        endfunction

        // accepted command word: update the ring copy and queue the expected word
        function void note_command(cmd_t command, logic signed [15:0] left,
                                   logic signed [15:0] right);
            result_t want;
            want = '0;
            case (command)
                CMD_PUSH:
                begin
                    if (frames_held() < RING_DEPTH - 1)
                    begin
                        left_ring[wr_ptr]  = left;
                        right_ring[wr_ptr] = right;
                        wr_ptr             = (wr_ptr + 1) % RING_DEPTH;
                        want.accepted      = 1'b1;
                    end
                end
                CMD_PULL:
                begin
                    if (frames_held() != 0)
                    begin
                        want.left        = scaled_sample(left_ring[rd_ptr]);
                        want.right       = scaled_sample(right_ring[rd_ptr]);
                        rd_ptr           = (rd_ptr + 1) % RING_DEPTH;
                        want.frame_valid = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    rd_ptr = wr_ptr;
                end
                default:
                begin
                end
            endcase
            want.fill_level = 10'(frames_held());
            pending_results.push_back(want);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("[%0t] result word %0d: %s got %0d expected %0d",
                     $time, word_count, what, got, want);
            error_count++;
        endtask

        // compare one result word with the oldest expectation
        task check_word(result_t got);
            result_t want;
            word_count++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("word with nothing pending, fill_level", got.fill_level, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.accepted !== want.accepted)
                    report_mismatch("accepted", got.accepted, want.accepted);
                if (got.frame_valid !== want.frame_valid)
                    report_mismatch("frame_valid", got.frame_valid, want.frame_valid);
                if (got.left !== want.left)
                    report_mismatch("left_out", got.left, want.left);
                if (got.right !== want.right)
                    report_mismatch("right_out", got.right, want.right);
                if (got.fill_level !== want.fill_level)
                    report_mismatch("fill_level", got.fill_level, want.fill_level);
            end
        endtask

        // words still owed by the block at the end of the run
        task check_leftovers();
            if (pending_results.size() != 0)
                report_mismatch("words never delivered", pending_results.size(), 0);
        endtask
    endclass

    localparam int CYCLE_LIMIT = 400000;

    typedef enum
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic clk;
    logic rst_n;

    int   sender_idle_pct;
    int   receiver_stall_pct;
    int   holdoff_cycles;
    int   cycle_count;

    audio_ring_scoreboard ring_sb;

    saf_in_if  item_ch ();
    saf_out_if result_ch ();
    saf_cfg_if cfg_ch ();

    stereo_audio_fifo_with_gain i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("FAIL");
                $finish;
            end
        end
    end

    // receiver: long hold-off first, otherwise random stalls
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_cycles > 0)
            begin
                result_ch.ready = 1'b0;
                holdoff_cycles--;
            end
            else
            begin
                result_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            ring_sb.check_word(result_t'({result_ch.accepted, result_ch.frame_valid,
                                          result_ch.left_out, result_ch.right_out,
                                          result_ch.fill_level}));
    end

    task automatic set_idle_mode(idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                sender_idle_pct    = 59;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 59;
            end
            default:
            begin
                sender_idle_pct    = 15;
                receiver_stall_pct = 15;
            end
        endcase
    endtask

    // offer one command word, valid stays high after acceptance
    task automatic send_word(cmd_t command, logic [15:0] left, logic [15:0] right);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid    = 1'b1;
        item_ch.command  = command;
        item_ch.left_in  = left;
        item_ch.right_in = right;
        do
            @(posedge clk);
        while (!item_ch.ready);
        ring_sb.note_command(command, left, right);
    endtask

    // stop offering and wait for every owed result word
    task automatic wait_ring_idle();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (ring_sb.pending_count() != 0)
            @(posedge clk);
    endtask

    // gain register write, only with the block idle
    task automatic write_volume(logic [15:0] value);
        @(negedge clk);
        cfg_ch.valid  = 1'b1;
        cfg_ch.volume = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        ring_sb.set_gain(value);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_volume();
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(32768));
    endfunction

    function automatic cmd_t pick_command(int push_pct, int pull_pct, int clear_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < push_pct)
            return CMD_PUSH;
        if (roll < push_pct + pull_pct)
            return CMD_PULL;
        if (roll < push_pct + pull_pct + clear_pct)
            return CMD_CLEAR;
        return CMD_NOP;
    endfunction

    task automatic run_mixed(int count, int push_pct, int pull_pct, int clear_pct);
        for (int n = 0; n < count; n++)
            send_word(pick_command(push_pct, pull_pct, clear_pct), pick_sample(),
                      pick_sample());
    endtask

    // stimulus
    initial
    begin
        ring_sb            = new();
        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.command    = CMD_NOP;
        item_ch.left_in    = '0;
        item_ch.right_in   = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.volume      = '0;
        holdoff_cycles     = 0;
        set_idle_mode(IDLE_NONE);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // unity gain: underrun, extremes, no-op, drain past empty
        send_word(CMD_PULL, 16'h1234, 16'h4321);
        send_word(CMD_PUSH, 16'h7FFF, 16'h8000);
        send_word(CMD_PUSH, 16'h8000, 16'h7FFF);
        send_word(CMD_PUSH, 16'h0001, 16'hFFFF);
        send_word(CMD_NOP, 16'hFFFF, 16'hFFFF);
        send_word(CMD_PULL, 16'h0000, 16'h0000);
        send_word(CMD_PULL, 16'h0000, 16'h0000);
        send_word(CMD_PULL, 16'h0000, 16'h0000);
        send_word(CMD_PULL, 16'h0000, 16'h0000);
        wait_ring_idle();

        // full gain: clamping at both ends
        write_volume(VOL_MAX);
        send_word(CMD_PUSH, 16'h7FFF, 16'h8000);
        send_word(CMD_PUSH, 16'h4000, 16'hBFFF);
        send_word(CMD_PULL, 16'h0000, 16'h0000);
        send_word(CMD_PULL, 16'h0000, 16'h0000);
        wait_ring_idle();

        // zero gain, clear then pull from an empty ring
        write_volume(16'h0000);
        send_word(CMD_PUSH, 16'h8000, 16'h3039);
        send_word(CMD_PUSH, 16'h0007, 16'h0007);
        send_word(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
        send_word(CMD_PULL, 16'h0000, 16'h0000);
        send_word(CMD_PUSH, 16'hFFFF, 16'h0001);
        send_word(CMD_PULL, 16'h0000, 16'h0000);
        wait_ring_idle();

        // register value beyond 2.0 is clamped
        write_volume(16'hFFFF);
        send_word(CMD_PUSH, 16'hFFFF, 16'h0001);
        send_word(CMD_PULL, 16'h0000, 16'h0000);
        send_word(CMD_CLEAR, 16'h0000, 16'h0000);
        wait_ring_idle();

        // balanced traffic, no idling
        write_volume(pick_volume());
        run_mixed(120, 45, 40, 5);
        wait_ring_idle();

        // balanced traffic, sender gaps
        set_idle_mode(IDLE_SENDER);
        write_volume(VOL_MAX);
        run_mixed(120, 45, 40, 5);
        wait_ring_idle();

        // fill the ring to full behind a long receiver hold-off
        set_idle_mode(IDLE_RECEIVER);
        write_volume(pick_volume());
        holdoff_cycles = 300;
        run_mixed(1150, 97, 2, 0);
        wait_ring_idle();

        // drain with both sides idling
        set_idle_mode(IDLE_BOTH);
        write_volume(pick_volume());
        run_mixed(400, 12, 85, 1);
        wait_ring_idle();

        // tiny gain, second hold-off mid-stream
        set_idle_mode(IDLE_NONE);
        write_volume(16'h0001);
        run_mixed(75, 45, 40, 5);
        holdoff_cycles = 200;
        run_mixed(75, 45, 40, 5);
        wait_ring_idle();

        repeat (10) @(posedge clk);
        ring_sb.check_leftovers();
        if (ring_sb.error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
